[rtl/lrupr_pkg.sv]
// Shared constants and types for the LRU page replacement unit.
package lrupr_pkg;

  localparam int MAX_FRAME_COUNT = 8;
  localparam int PAGE_BITS       = 16;

  localparam int PAGE_FIELD_W  = 16;
  localparam int FRAME_FIELD_W = 3;
  localparam int NUM_FRAMES_W  = 4;
  localparam int FAULT_W       = 32;

  localparam int FRAME_IDX_W = (MAX_FRAME_COUNT > 1) ? $clog2(MAX_FRAME_COUNT) : 1;
  localparam int RANK_W      = FRAME_IDX_W;

  localparam logic [NUM_FRAMES_W-1:0] NUM_FRAMES_RESET = NUM_FRAMES_W'(MAX_FRAME_COUNT);
  localparam logic [RANK_W-1:0]       RANK_OLDEST      = RANK_W'(MAX_FRAME_COUNT - 1);

  typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
  typedef logic [RANK_W-1:0]      rank_t;
  typedef logic [PAGE_BITS-1:0]   page_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lrupr_state_t;

  typedef struct packed {
    logic  valid;
    page_t page;
    rank_t rank;
  } frame_rd_t;

  typedef struct packed {
    logic       en;
    frame_idx_t slot;
    logic       wr_page;
    page_t      page;
    logic       slot_valid;
    rank_t      slot_rank;
  } frame_upd_t;

endpackage

[rtl/lrupr_req_if.sv]
// Page reference channel: valid, ready and the referenced page.
interface lrupr_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [lrupr_pkg::PAGE_FIELD_W-1:0]   page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

[rtl/lrupr_rsp_if.sv]
// Result channel: valid, ready and the outcome of one page reference.
interface lrupr_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  fault;
  logic [lrupr_pkg::FRAME_FIELD_W-1:0]   frame_index;
  logic                                  evicted_valid;
  logic [lrupr_pkg::PAGE_FIELD_W-1:0]    evicted_page;
  logic [lrupr_pkg::FAULT_W-1:0]         fault_count;

  modport source (output valid, output fault, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input fault, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

[rtl/lrupr_frame_store.sv]
// Frame table: page numbers, valid bits and recency ranks with one read port.
module lrupr_frame_store (
  input  logic                  clk,
  input  logic                  rst,
  input  lrupr_pkg::frame_idx_t rd_idx,
  output lrupr_pkg::frame_rd_t  rd,
  input  lrupr_pkg::frame_upd_t upd
);
  import lrupr_pkg::*;

  page_t frame_page [MAX_FRAME_COUNT];
  logic  frame_valid [MAX_FRAME_COUNT];
  rank_t recency_rank [MAX_FRAME_COUNT];

  always_comb begin
    rd.valid = frame_valid[rd_idx];
    rd.page  = frame_page[rd_idx];
    rd.rank  = recency_rank[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.wr_page) begin
      frame_page[upd.slot] <= upd.page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_FRAME_COUNT; j++) begin
        frame_valid[j]  <= 1'b0;
        recency_rank[j] <= '0;
      end
    end else if (upd.en) begin
      for (int j = 0; j < MAX_FRAME_COUNT; j++) begin
        if (frame_idx_t'(j) == upd.slot) begin
          frame_valid[j]  <= 1'b1;
          recency_rank[j] <= '0;
        end else if (frame_valid[j] && (!upd.slot_valid || recency_rank[j] < upd.slot_rank)
                     && recency_rank[j] < RANK_OLDEST) begin
          recency_rank[j] <= recency_rank[j] + rank_t'(1);
        end
      end
    end
  end

endmodule

[rtl/lru_page_replacement_unit.sv]
// Top level of the LRU page replacement unit: sequencer, scan unit and result register.
//
//   channel   dir   handshake        payload
//   req       in    valid/ready      page_number
//   rsp       out   valid/ready      fault, frame_index, evicted_valid, evicted_page,
//                                    fault_count
//   cfg       in    cfg_wr_en        cfg_wr_data (num_frames)
//
// A transaction steps through accept, then one compare per configured frame walked by the single scan
// comparator (a hit stops the walk early; num_frames of 0 counts as 1 and above 8 as 8), then an
// update that writes the table and loads the result register.
// Reset clears valid bits, ranks, the fault count and sets num_frames to its maximum.
// A pending result stalls only the update step; req is ready whenever the sequencer is idle.
module lru_page_replacement_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lrupr_pkg::NUM_FRAMES_W-1:0]  cfg_wr_data,
  lrupr_req_if.sink                           req,
  lrupr_rsp_if.source                         rsp
);
  import lrupr_pkg::*;

  lrupr_state_t state, state_next;

  logic [NUM_FRAMES_W-1:0] num_frames;
  frame_idx_t              last_idx;

  page_t      page;
  frame_idx_t idx;
  logic       hit;
  frame_idx_t hit_idx;
  rank_t      hit_rank;
  logic       empty_found;
  frame_idx_t empty_idx;
  frame_idx_t victim_idx;
  rank_t      victim_rank;
  page_t      victim_page;
  logic [FAULT_W-1:0] fault_total;

  frame_rd_t  rd;
  frame_upd_t upd;

  logic       match;
  logic       scan_done;
  logic       update_go;
  frame_idx_t slot;

  lrupr_frame_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (idx),
    .rd     (rd),
    .upd    (upd)
  );

  always_comb begin
    priority if (num_frames == '0) begin
      last_idx = '0;
    end else if (int'(num_frames) > MAX_FRAME_COUNT) begin
      last_idx = frame_idx_t'(MAX_FRAME_COUNT - 1);
    end else begin
      last_idx = frame_idx_t'(num_frames - NUM_FRAMES_W'(1));
    end
  end

  assign match     = rd.valid && (rd.page == page);
  assign scan_done = match || (idx == last_idx);
  assign update_go = !rsp.valid || rsp.ready;

  always_comb begin
    priority if (hit) begin
      slot = hit_idx;
    end else if (empty_found) begin
      slot = empty_idx;
    end else begin
      slot = victim_idx;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req.valid) state_next = ST_SCAN;
      ST_SCAN:   if (scan_done) state_next = ST_UPDATE;
      ST_UPDATE: if (update_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready      = (state == ST_IDLE);
    upd.en         = (state == ST_UPDATE) && update_go;
    upd.slot       = slot;
    upd.wr_page    = !hit;
    upd.page       = page;
    upd.slot_valid = hit || !empty_found;
    upd.slot_rank  = hit ? hit_rank : victim_rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      num_frames  <= NUM_FRAMES_RESET;
      fault_total <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        num_frames <= cfg_wr_data;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (upd.en) begin
        rsp.valid <= 1'b1;
        if (!hit && fault_total != '1) begin
          fault_total <= fault_total + FAULT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      page        <= PAGE_BITS'(req.page_number);
      idx         <= '0;
      hit         <= 1'b0;
      empty_found <= 1'b0;
    end
    if (state == ST_SCAN) begin
      if (match) begin
        hit      <= 1'b1;
        hit_idx  <= idx;
        hit_rank <= rd.rank;
      end else begin
        if (!rd.valid && !empty_found) begin
          empty_found <= 1'b1;
          empty_idx   <= idx;
        end
        if (idx == '0 || rd.rank > victim_rank) begin
          victim_idx  <= idx;
          victim_rank <= rd.rank;
          victim_page <= rd.page;
        end
      end
      if (!scan_done) begin
        idx <= idx + frame_idx_t'(1);
      end
    end
    if (upd.en) begin
      rsp.fault         <= !hit;
      rsp.frame_index   <= FRAME_FIELD_W'(slot);
      rsp.evicted_valid <= !hit && !empty_found;
      rsp.evicted_page  <= (!hit && !empty_found) ? PAGE_FIELD_W'(victim_page) : '0;
      rsp.fault_count   <= (!hit && fault_total != '1) ? fault_total + FAULT_W'(1)
                                                        : fault_total;
    end
  end

endmodule

[tb/tb_lru_page_replacement_unit.sv]
// Self-checking testbench for the LRU page replacement unit with a transaction-level table model.
`timescale 1ns / 1ps

module tb_lru_page_replacement_unit;
  import lrupr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDLE_PCT       = 23;

  typedef struct packed {
    logic                     fault;
    logic [FRAME_FIELD_W-1:0] frame_index;
    logic                     evicted_valid;
    logic [PAGE_FIELD_W-1:0]  evicted_page;
    logic [FAULT_W-1:0]       fault_count;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [NUM_FRAMES_W-1:0] cfg_wr_data;

  lrupr_req_if req_if ();
  lrupr_rsp_if rsp_if ();

  lru_page_replacement_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  page_t                   tbl_page  [MAX_FRAME_COUNT];
  logic                    tbl_valid [MAX_FRAME_COUNT];
  rank_t                   tbl_rank  [MAX_FRAME_COUNT];
  logic [FAULT_W-1:0]      fault_total;
  logic [NUM_FRAMES_W-1:0] frames_cfg;

  lookup_result_t pending_results[$];
  lookup_result_t want_result;

  int error_count;
  int quiet_cycles;
  int hold_request;
  int hold_left;
  bit idle_en;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic lookup_result_t lookup_page(input page_t pg);
    lookup_result_t r;
    int nf;
    int slot;
    bit hit;
    bit empty;
    r     = '0;
    hit   = 1'b0;
    empty = 1'b0;
    slot  = 0;
    nf    = (frames_cfg == 0) ? 1 :
            (frames_cfg > MAX_FRAME_COUNT) ? MAX_FRAME_COUNT : int'(frames_cfg);
    for (int j = 0; j < nf; j++) begin
      if (!hit && tbl_valid[j] && tbl_page[j] == pg) begin
        hit  = 1'b1;
        slot = j;
      end
    end
    if (!hit) begin
      for (int j = 0; j < nf; j++) begin
        if (!empty && !tbl_valid[j]) begin
          empty = 1'b1;
          slot  = j;
        end
      end
      if (!empty) begin
        slot = 0;
        for (int j = 1; j < nf; j++) begin
          if (tbl_rank[j] > tbl_rank[slot]) slot = j;
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = tbl_page[slot];
      end
      tbl_page[slot] = pg;
      if (fault_total != '1) fault_total++;
    end
    for (int j = 0; j < MAX_FRAME_COUNT; j++) begin
      if (j != slot && tbl_valid[j] && (!tbl_valid[slot] || tbl_rank[j] < tbl_rank[slot]) &&
          tbl_rank[j] < RANK_OLDEST) begin
        tbl_rank[j]++;
      end
    end
    tbl_rank[slot]  = '0;
    tbl_valid[slot] = 1'b1;
    r.fault       = !hit;
    r.frame_index = FRAME_FIELD_W'(slot);
    r.fault_count = fault_total;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    error_count++;
  endtask

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_page(input page_t pg);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.page_number <= pg;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(lookup_page(pg));
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_num_frames(input logic [NUM_FRAMES_W-1:0] value);
    drain_results();
    repeat (2) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    frames_cfg = value;
  endtask

  task automatic test_reset_fill();
    send_page(16'h0000);
    send_page(16'hFFFF);
    for (int p = 1; p <= 6; p++) send_page(page_t'(p));
    send_page(16'h0000);
    send_page(16'h8000);
  endtask

  task automatic test_shrink_grow();
    write_num_frames(NUM_FRAMES_W'(2));
    send_page(16'h0004);
    write_num_frames(NUM_FRAMES_RESET);
    send_page(16'h0004);
    send_page(16'hFFFF);
  endtask

  task automatic test_frame_count_limits();
    write_num_frames(NUM_FRAMES_W'(0));
    send_page(16'h1234);
    send_page(16'h1234);
    send_page(16'h5A5A);
    write_num_frames(NUM_FRAMES_W'(15));
    send_page(16'h1234);
    send_page(16'hA5A5);
  endtask

  task automatic test_random_traffic();
    logic [NUM_FRAMES_W-1:0] settings[12] = '{1, 8, 0, 15, 4, 2, 7, 3, 5, 6, 9, 12};
    page_t work_set[16];
    page_t pg;
    int eff;
    int ws;
    foreach (settings[s]) begin
      write_num_frames(settings[s]);
      eff = (settings[s] == 0) ? 1 :
            (settings[s] > MAX_FRAME_COUNT) ? MAX_FRAME_COUNT : int'(settings[s]);
      ws = eff + $urandom_range(4);
      for (int k = 0; k < 16; k++) work_set[k] = page_t'($urandom_range(16'hFFFF));
      repeat (90) begin
        if ($urandom_range(99) < 80) pg = work_set[$urandom_range(ws - 1)];
        else pg = page_t'($urandom_range(16'hFFFF));
        send_page(pg);
      end
    end
  endtask

  task automatic test_no_idle();
    page_t work_set[10];
    write_num_frames(NUM_FRAMES_RESET);
    for (int k = 0; k < 10; k++) work_set[k] = page_t'($urandom_range(16'hFFFF));
    idle_en = 1'b0;
    repeat (150) send_page(work_set[$urandom_range(9)]);
    drain_results();
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    page_t work_set[6];
    write_num_frames(NUM_FRAMES_W'(4));
    for (int k = 0; k < 6; k++) work_set[k] = page_t'($urandom_range(16'hFFFF));
    hold_request = 300;
    repeat (40) send_page(work_set[$urandom_range(5)]);
  endtask

  task automatic test_sender_pause();
    write_num_frames(NUM_FRAMES_W'(3));
    repeat (30) send_page(page_t'($urandom_range(7)));
    drain_results();
    repeat (30) send_page(page_t'($urandom_range(7)));
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, fault_count", rsp_if.fault_count, 0);
      end else begin
        want_result = pending_results.pop_front();
        if (rsp_if.fault !== want_result.fault)
          report_mismatch("fault", rsp_if.fault, want_result.fault);
        if (rsp_if.frame_index !== want_result.frame_index)
          report_mismatch("frame_index", rsp_if.frame_index, want_result.frame_index);
        if (rsp_if.evicted_valid !== want_result.evicted_valid)
          report_mismatch("evicted_valid", rsp_if.evicted_valid, want_result.evicted_valid);
        if (rsp_if.evicted_page !== want_result.evicted_page)
          report_mismatch("evicted_page", rsp_if.evicted_page, want_result.evicted_page);
        if (rsp_if.fault_count !== want_result.fault_count)
          report_mismatch("fault_count", rsp_if.fault_count, want_result.fault_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_lru_page_replacement_unit: done, errors");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_if.valid       = 1'b0;
    req_if.page_number = '0;
    rsp_if.ready       = 1'b0;
    idle_en            = 1'b1;
    hold_request       = 0;
    hold_left          = 0;
    error_count        = 0;
    quiet_cycles       = 0;
    fault_total        = '0;
    frames_cfg         = NUM_FRAMES_RESET;
    for (int k = 0; k < MAX_FRAME_COUNT; k++) begin
      tbl_page[k]  = '0;
      tbl_valid[k] = 1'b0;
      tbl_rank[k]  = '0;
    end
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_reset_fill();
    test_shrink_grow();
    test_frame_count_limits();
    test_random_traffic();
    test_no_idle();
    test_backpressure();
    test_sender_pause();
    drain_results();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_lru_page_replacement_unit: done, clean");
    end else begin
      $display("tb_lru_page_replacement_unit: done, errors");
    end
    $finish;
  end

endmodule
